/* src/cau_pkg.sv */
// package for the complex arithmetic unit: command codes, widths, defaults
// no dependencies
package cau_pkg;

    localparam int DataW        = 32;
    localparam int CmdW         = 3;
    localparam int ExpW         = 5;
    localparam int MaxExpDef    = 16;
    localparam int FracBitsDef  = 16;

    typedef enum logic [CmdW-1:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_CONJ = 3'd4,
        CMD_POW  = 3'd5
    } t_cmd;

    // classified word passed from front to back
    typedef struct packed {
        logic [CmdW-1:0]           cmd;
        logic signed [DataW-1:0]   ar;
        logic signed [DataW-1:0]   ai;
        logic signed [DataW-1:0]   br;
        logic signed [DataW-1:0]   bi;
        logic [6:0]                mults;   // complex multiplies still needed
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

    // clamp a 66-bit signed value to 32 bits
    function automatic logic [DataW:0] clamp66(input logic signed [65:0] v);
        logic [DataW:0] r;
        if (v > 66'sh7FFFFFFF)
            r = {1'b1, 32'h7FFFFFFF};
        else if (v < -66'sh80000000)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, v[DataW-1:0]};
        return r;
    endfunction

endpackage

/* src/cau_front.sv */
// front end: accepts a word, classifies it and computes the multiply count
// depends on cau_pkg
module cau_front #(
    parameter int MAX_EXPONENT = cau_pkg::MaxExpDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cau_pkg::CmdW-1:0]   i_command,
    input  logic [cau_pkg::DataW-1:0]  i_a_real,
    input  logic [cau_pkg::DataW-1:0]  i_a_imag,
    input  logic [cau_pkg::DataW-1:0]  i_b_real,
    input  logic [cau_pkg::DataW-1:0]  i_b_imag,
    input  logic [cau_pkg::ExpW-1:0]   i_exponent,
    output logic                       o_job_valid,
    input  logic                       i_job_pop,
    output cau_pkg::t_job              o_job
);
    import cau_pkg::*;

    // two-entry queue
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job n_job;
    logic [6:0] w_ex, w_cap;
    logic w_push, w_pop;

    // classify: multiplies needed for power, one for multiply
    always_comb begin
        w_ex  = {2'b0, i_exponent};
        w_cap = (w_ex > 7'(MAX_EXPONENT)) ? 7'(MAX_EXPONENT) : w_ex;
        n_job.cmd = i_command;
        n_job.ar  = i_a_real;
        n_job.ai  = i_a_imag;
        n_job.br  = i_b_real;
        n_job.bi  = i_b_imag;
        n_job.mults = 7'd0;
        if (i_command == CMD_MUL)
            n_job.mults = 7'd1;
        else if (i_command == CMD_POW && w_cap > 7'd1) begin
            n_job.mults = w_cap - 7'd1;
            n_job.br = i_a_real;
            n_job.bi = i_a_imag;
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* src/cau_back.sv */
// back end: shared multiplier, serial divider, saturation, output register
// depends on cau_pkg
module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FracBitsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_pop,
    input  cau_pkg::t_job              i_job,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cau_pkg::DataW-1:0]  o_res_real,
    output logic [cau_pkg::DataW-1:0]  o_res_imag,
    output logic                       o_divide_by_zero,
    output logic                       o_saturated
);
    import cau_pkg::*;

    localparam int DivSteps = 64 + FRAC_BITS;
    localparam int QCap = 34;

    t_state r_st, n_st;
    t_job   r_job;
    logic signed [DataW-1:0] r_xr, r_xi;   // running value
    logic [6:0] r_left;
    logic [1:0] r_pi;                      // product index
    logic signed [63:0] r_p [4];
    logic r_sat, r_dz;
    // divider
    logic [63:0] r_den, r_shr, r_shi;
    logic [64:0] r_remr, r_remi;
    logic [QCap-1:0] r_qr, r_qi;
    logic r_negr, r_negi;
    logic [6:0] r_k;
    // output register
    logic r_ov;
    logic [DataW-1:0] r_or, r_oi;
    logic r_odz, r_osat;

    logic w_take, w_out_free;
    logic signed [DataW-1:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_sr, w_si, w_fr, w_fi;
    logic [DataW:0] w_cr, w_ci;
    logic [64:0] w_trr, w_tri;
    logic [QCap-1:0] w_nqr, w_nqi;
    logic signed [65:0] w_qr, w_qi;

    assign w_out_free = !r_ov || !i_stall;
    assign w_take = (r_st == ST_IDLE) && i_job_valid;

    // operand select for the one shared multiplier
    always_comb begin
        case (r_pi)
            2'd0: begin w_ma = r_xr; w_mb = r_job.br; end
            2'd1: begin w_ma = r_xi; w_mb = r_job.bi; end
            2'd2: begin w_ma = r_xr; w_mb = r_job.bi; end
            default: begin w_ma = r_xi; w_mb = r_job.br; end
        endcase
        w_prod = 64'(w_ma) * 64'(w_mb);
    end

    // product sums, floor shift for multiply
    always_comb begin
        w_sr = 66'(r_p[0]) - 66'(r_p[1]);
        w_si = 66'(r_p[2]) + 66'(r_p[3]);
        w_fr = w_sr >>> FRAC_BITS;
        w_fi = w_si >>> FRAC_BITS;
        w_cr = clamp66(w_fr);
        w_ci = clamp66(w_fi);
    end

    // one restoring divide step on each part
    always_comb begin
        w_trr = {r_remr[63:0], r_shr[63]};
        w_tri = {r_remi[63:0], r_shi[63]};
        w_nqr = (r_qr < QCap'(1) << 33) ? {r_qr[QCap-2:0], 1'b0} : r_qr;
        w_nqi = (r_qi < QCap'(1) << 33) ? {r_qi[QCap-2:0], 1'b0} : r_qi;
        if (w_trr >= {1'b0, r_den} && r_qr < QCap'(1) << 33) w_nqr[0] = 1'b1;
        if (w_tri >= {1'b0, r_den} && r_qi < QCap'(1) << 33) w_nqi[0] = 1'b1;
        w_qr = r_negr ? -66'(r_qr) : 66'(r_qr);
        w_qi = r_negi ? -66'(r_qi) : 66'(r_qi);
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_job_valid) begin
                if (i_job.mults != 7'd0 || i_job.cmd == CMD_DIV) n_st = ST_MUL;
                else n_st = ST_DONE;
            end
            ST_MUL:  if (r_pi == 2'd3) n_st = ST_SUM;
            ST_SUM:  begin
                if (r_job.cmd == CMD_DIV)
                    n_st = (r_p[0] == 64'sd0 && r_p[1] == 64'sd0 && r_p[2] == 64'sd0
                            && r_p[3] == 64'sd0) ? ST_DONE : ST_DIV;
                else if (r_left > 7'd1) n_st = ST_MUL;
                else n_st = ST_DONE;
            end
            ST_DIV:  if (r_k == 7'(DivSteps - 1)) n_st = ST_DONE;
            ST_DONE: if (w_out_free) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_job_pop = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: if (w_take) begin
                r_job <= i_job;
                r_xr <= i_job.ar; r_xi <= i_job.ai;
                r_left <= i_job.mults;
                r_pi <= 2'd0; r_sat <= 1'b0; r_dz <= 1'b0;
            end
            ST_MUL: begin
                r_p[r_pi] <= w_prod;
                r_pi <= r_pi + 2'd1;
            end
            ST_SUM: begin
                r_pi <= 2'd0;
                if (r_job.cmd == CMD_DIV) begin
                    // set up both dividers from the product sums
                    r_k <= 7'd0;
                    r_remr <= 65'd0; r_remi <= 65'd0;
                    r_qr <= '0; r_qi <= '0;
                    r_negr <= (66'(r_p[0]) + 66'(r_p[1])) < 0;
                    r_shr <= 64'(((66'(r_p[0]) + 66'(r_p[1])) < 0) ?
                              -(66'(r_p[0]) + 66'(r_p[1])) : (66'(r_p[0]) + 66'(r_p[1])));
                    r_negi <= (66'(r_p[3]) - 66'(r_p[2])) < 0;
                    r_shi <= 64'(((66'(r_p[3]) - 66'(r_p[2])) < 0) ?
                              -(66'(r_p[3]) - 66'(r_p[2])) : (66'(r_p[3]) - 66'(r_p[2])));
                    if (r_den == 64'd0) r_dz <= 1'b1;
                end else begin
                    r_xr <= w_cr[DataW-1:0]; r_xi <= w_ci[DataW-1:0];
                    r_sat <= r_sat | w_cr[DataW] | w_ci[DataW];
                    r_left <= r_left - 7'd1;
                end
            end
            ST_DIV: begin
                r_k <= r_k + 7'd1;
                r_shr <= {r_shr[62:0], 1'b0};
                r_shi <= {r_shi[62:0], 1'b0};
                r_remr <= (w_trr >= {1'b0, r_den}) ? w_trr - {1'b0, r_den} : w_trr;
                r_remi <= (w_tri >= {1'b0, r_den}) ? w_tri - {1'b0, r_den} : w_tri;
                r_qr <= w_nqr; r_qi <= w_nqi;
            end
            default: ;
        endcase
    end

    // divisor: |b|^2, computed on accept with two 32x32 products
    always_ff @(posedge i_clk) begin
        if (w_take)
            r_den <= 64'(64'(i_job.br) * 64'(i_job.br)) + 64'(64'(i_job.bi) * 64'(i_job.bi));
    end

    // result formation and output register
    logic [DataW:0] w_rr, w_ri;
    always_comb begin
        w_rr = '0; w_ri = '0;
        case (r_job.cmd)
            CMD_ADD: begin
                w_rr = clamp66(66'(r_job.ar) + 66'(r_job.br));
                w_ri = clamp66(66'(r_job.ai) + 66'(r_job.bi));
            end
            CMD_SUB: begin
                w_rr = clamp66(66'(r_job.ar) - 66'(r_job.br));
                w_ri = clamp66(66'(r_job.ai) - 66'(r_job.bi));
            end
            CMD_CONJ: begin
                w_rr = {1'b0, r_job.ar};
                w_ri = clamp66(-66'(r_job.ai));
            end
            CMD_MUL, CMD_POW: begin
                w_rr = {r_sat, r_xr};
                w_ri = {1'b0, r_xi};
            end
            CMD_DIV: begin
                if (!r_dz) begin
                    w_rr = clamp66(w_qr);
                    w_ri = clamp66(w_qi);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (r_st == ST_DONE && w_out_free) r_ov <= 1'b1;
        else if (!i_stall) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_DONE && w_out_free) begin
            r_or  <= w_rr[DataW-1:0];
            r_oi  <= w_ri[DataW-1:0];
            r_odz <= (r_job.cmd == CMD_DIV) && r_dz;
            r_osat <= w_rr[DataW] | w_ri[DataW];
        end
    end

    assign o_valid = r_ov;
    assign o_res_real = r_or;
    assign o_res_imag = r_oi;
    assign o_divide_by_zero = r_odz;
    assign o_saturated = r_osat;

endmodule

/* src/complex_arithmetic_unit_top.sv */
// Complex ALU on signed Q16.16 operands. A two-entry front queue takes words
// until it is full; the back end uses one shared 32x32 multiplier (four
// products per complex multiply, plus a sum step), a pair of 32x32 products
// for the divisor magnitude, and a one-bit-per-cycle divider (80 steps).
// Add, subtract and conjugate skip the multiplier; power repeats the multiply
// and sum steps once per multiply, and divide adds the divider steps.
// depends on cau_pkg, cau_front, cau_back
module complex_arithmetic_unit_top #(
    parameter int MAX_EXPONENT = cau_pkg::MaxExpDef,
    parameter int FRAC_BITS    = cau_pkg::FracBitsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cau_pkg::CmdW-1:0]   i_command,
    input  logic [cau_pkg::DataW-1:0]  i_a_real,
    input  logic [cau_pkg::DataW-1:0]  i_a_imag,
    input  logic [cau_pkg::DataW-1:0]  i_b_real,
    input  logic [cau_pkg::DataW-1:0]  i_b_imag,
    input  logic [cau_pkg::ExpW-1:0]   i_exponent,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cau_pkg::DataW-1:0]  o_res_real,
    output logic [cau_pkg::DataW-1:0]  o_res_imag,
    output logic                       o_divide_by_zero,
    output logic                       o_saturated
);
    import cau_pkg::*;

    t_job w_job;
    logic w_jv, w_pop;

    cau_front #(.MAX_EXPONENT(MAX_EXPONENT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_a_real, .i_a_imag,
        .i_b_real, .i_b_imag, .i_exponent,
        .o_job_valid(w_jv), .i_job_pop(w_pop), .o_job(w_job)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_pop(w_pop), .i_job(w_job),
        .o_valid, .i_stall, .o_res_real, .o_res_imag, .o_divide_by_zero,
        .o_saturated
    );

    // pop only when a queued word exists
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n) w_pop |-> w_jv)
        else $error("pop on empty queue");
    // divide by zero result is zero
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_res_real == '0 && o_res_imag == '0))
        else $error("nonzero divide by zero result");

endmodule

/* dv/testbench.sv */
// testbench for complex_arithmetic_unit_top: random and directed complex words
// checked against a behavioral predictor in a small scoreboard class
// depends on cau_pkg and the complex_arithmetic_unit_top rtl
`timescale 1ns / 1ps

module testbench;
    import cau_pkg::*;

    typedef struct {
        logic [31:0] rr;
        logic [31:0] ri;
        logic        dz;
        logic        sat;
    } t_result;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] clamp_q(input logic signed [99:0] v,
                                                   inout logic sat);
        if (v > 100'sh7FFFFFFF) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -100'sh80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // floor shift of a sum of products, then clamp
    function automatic logic signed [31:0] scale_q(input logic signed [99:0] v,
                                                   inout logic sat);
        logic signed [99:0] s;
        s = v >>> FracBitsDef;
        return clamp_q(s, sat);
    endfunction

    // complex multiply with floor rounding
    function automatic void cmul_q(input logic signed [31:0] ar, ai, br, bi,
                                   output logic signed [31:0] rr, ri,
                                   inout logic sat);
        logic signed [99:0] p;
        logic signed [99:0] q;
        p = 100'(ar) * 100'(br) - 100'(ai) * 100'(bi);
        q = 100'(ar) * 100'(bi) + 100'(ai) * 100'(br);
        rr = scale_q(p, sat);
        ri = scale_q(q, sat);
    endfunction

    // truncating divide part; quotient saturates anyway, so a wide divide is exact
    function automatic logic signed [31:0] div_q(input logic signed [99:0] num,
                                                 input logic signed [99:0] den,
                                                 inout logic sat);
        logic signed [99:0] n;
        n = num <<< FracBitsDef;
        return clamp_q(n / den, sat);
    endfunction

    function automatic t_result predict_complex(input logic [2:0] cmd,
            input logic signed [31:0] ar, ai, br, bi, input logic [4:0] ex);
        t_result r;
        logic sat;
        logic signed [31:0] xr, xi;
        logic signed [99:0] den;
        int n;
        sat = 1'b0;
        xr = '0;
        xi = '0;
        r.dz = 1'b0;
        case (cmd)
            CMD_ADD: begin
                xr = clamp_q(100'(ar) + 100'(br), sat);
                xi = clamp_q(100'(ai) + 100'(bi), sat);
            end
            CMD_SUB: begin
                xr = clamp_q(100'(ar) - 100'(br), sat);
                xi = clamp_q(100'(ai) - 100'(bi), sat);
            end
            CMD_MUL: cmul_q(ar, ai, br, bi, xr, xi, sat);
            CMD_DIV: begin
                den = 100'(br) * 100'(br) + 100'(bi) * 100'(bi);
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    xr = div_q(100'(ar) * 100'(br) + 100'(ai) * 100'(bi), den, sat);
                    xi = div_q(100'(br) * 100'(ai) - 100'(ar) * 100'(bi), den, sat);
                end
            end
            CMD_CONJ: begin
                xr = ar;
                xi = clamp_q(-100'(ai), sat);
            end
            CMD_POW: begin
                xr = ar;
                xi = ai;
                for (n = 1; n < ((ex > MaxExpDef) ? MaxExpDef : ex); n++)
                    cmul_q(xr, xi, ar, ai, xr, xi, sat);
            end
            default: ;
        endcase
        r.rr = xr;
        r.ri = xi;
        r.sat = sat;
        return r;
    endfunction

    class complex_scoreboard;
        t_result pending[$];
        int errors;

        function void note_word(logic [2:0] cmd, logic [31:0] ar, ai, br, bi,
                                logic [4:0] ex);
            pending.push_back(predict_complex(cmd, ar, ai, br, bi, ex));
        endfunction

        function void check_word(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.rr !== w.rr) begin
                $error("res_real exp %h got %h", w.rr, got.rr);
                errors++;
            end
            if (got.ri !== w.ri) begin
                $error("res_imag exp %h got %h", w.ri, got.ri);
                errors++;
            end
            if (got.dz !== w.dz) begin
                $error("divide_by_zero exp %b got %b", w.dz, got.dz);
                errors++;
            end
            if (got.sat !== w.sat) begin
                $error("saturated exp %b got %b", w.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [31:0] i_a_real = '0, i_a_imag = '0, i_b_real = '0, i_b_imag = '0;
    logic [4:0]  i_exponent = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_res_real, o_res_imag;
    logic        o_divide_by_zero, o_saturated;

    complex_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  rx_on = 1'b0;

    complex_arithmetic_unit_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // accepted inputs and outputs sampled at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall)
            sb.note_word(i_command, i_a_real, i_a_imag, i_b_real, i_b_imag, i_exponent);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word('{o_res_real, o_res_imag, o_divide_by_zero, o_saturated});
        if (cycles > 1000000) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk)
        i_stall <= rx_on && !calm && ($urandom_range(99) < 16);

    task automatic send_word(logic [2:0] cmd, logic [31:0] ar, ai, br, bi,
                             logic [4:0] ex);
        while (!calm && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        i_exponent <= ex;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // operand with a bias toward small magnitudes and extremes
    function automatic logic [31:0] pick_operand(int big_pct);
        int k;
        k = $urandom_range(99);
        if (k < 5) return 32'h80000000;
        if (k < 10) return 32'h7FFFFFFF;
        if (k < 15) return 32'h0;
        if (k < 15 + big_pct) return $urandom;
        return 32'($signed($urandom_range(32'h3FFFF)) - 32'sh20000);
    endfunction

    initial begin
        logic [31:0] mx, mn, one;
        logic [2:0] c;
        int i;
        mx = 32'h7FFFFFFF;
        mn = 32'h80000000;
        one = 32'h00010000;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_on <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send_word(CMD_ADD, mx, mn, mx, mn, 0);
        send_word(CMD_SUB, mn, mx, mx, mn, 0);
        send_word(CMD_SUB, one, 0, 0, one, 0);
        send_word(CMD_MUL, mx, mx, mx, mn, 0);
        send_word(CMD_MUL, 32'hFFFFFFFF, 0, 1, 0, 0);
        send_word(CMD_MUL, one, one, one, 32'hFFFF0000, 0);
        send_word(CMD_DIV, one, one, 0, 0, 0);
        send_word(CMD_DIV, mx, mn, 1, 0, 0);
        send_word(CMD_DIV, mn, mx, mn, mn, 0);
        send_word(CMD_DIV, 32'hFFFFFFFF, 0, 32'h00030000, 0, 0);
        send_word(CMD_CONJ, mn, mn, 0, 0, 0);
        send_word(CMD_CONJ, mx, mx, 0, 0, 0);
        send_word(CMD_POW, 32'h00018000, one, 0, 0, 0);
        send_word(CMD_POW, 32'h00018000, one, 0, 0, 1);
        send_word(CMD_POW, 32'h00008000, 32'h00008000, 0, 0, 16);
        send_word(CMD_POW, 32'h00020000, 0, 0, 0, 31);
        send_word(CMD_POW, mn, mx, 0, 0, 3);
        send_word(3'd6, mx, mx, mx, mx, 31);
        send_word(3'd7, mn, mn, mn, mn, 5'h15);

        // random words, with a calm stretch in the middle
        for (i = 0; i < 1700; i++) begin
            calm = (i >= 600 && i < 800);
            c = ($urandom_range(99) < 3) ? 3'($urandom_range(7, 6))
                                         : 3'($urandom_range(5));
            send_word(c, pick_operand(30), pick_operand(30),
                      pick_operand(30), pick_operand(30), 5'($urandom));
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // drain
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
